@@ src/sss_pkg.sv @@
// Package for sample_set_statistics: sizes, status codes, sequencer states.
// No dependencies.
`default_nettype none
package sss_pkg;
  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int COUNT_W     = 11;
  localparam int DIV_W       = 64;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_DROPPED = 2'd2,
    ST_HARM    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_MEAN,
    S_MEAN_WAIT,
    S_RD,
    S_RD_WAIT,
    S_MUL,
    S_RECIP_WAIT,
    S_HARM,
    S_HARM_WAIT,
    S_VAR,
    S_VAR_WAIT,
    S_EMIT
  } state_t;
endpackage
`default_nettype wire

@@ src/sss_if.sv @@
// Channel interfaces for sample_set_statistics: sample input and result output.
// Depends on nothing.
`default_nettype none
interface sss_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic               last;
  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface sss_out_if;
  logic               valid;
  logic               ready;
  logic        [10:0] sample_count;
  logic signed [41:0] total;
  logic signed [31:0] largest;
  logic signed [31:0] smallest;
  logic signed [31:0] arith_mean;
  logic signed [31:0] harm_mean;
  logic        [48:0] variance;
  logic        [1:0]  status;
  modport source (output valid, output sample_count, output total, output largest,
                  output smallest, output arith_mean, output harm_mean,
                  output variance, output status, input ready);
  modport sink   (input valid, input sample_count, input total, input largest,
                  input smallest, input arith_mean, input harm_mean,
                  input variance, input status, output ready);
endinterface
`default_nettype wire

@@ src/sample_set_statistics.sv @@
// Sample set statistics: count, sum, extremes, arithmetic and harmonic mean,
// population variance of a set of signed Q16.16 samples.
// Depends on sss_pkg, sss_if (sss_in_if, sss_out_if) and sss_ram.
//
// Use: samples arrive on the "samples" channel, one transfer per cycle while
// loading. Zero samples are skipped; nonzero ones are written to the sample
// RAM until it holds MAX_SAMPLES, later ones are dropped and flagged.
// The transfer with last=1 closes the set (its own sample counts first).
// Then ready drops while the block computes: one 64-step divide for the
// mean, then per stored sample a RAM read, a square and a 64-step divide
// for the reciprocal, then two more 64-step divides for harmonic mean and
// variance (the harmonic one is skipped when the reciprocal sum is zero).
// All of them share one bit-serial divider; an empty set goes straight to
// the result.
// The result sits in an output register; if the receiver stalls, loading
// of the next set resumes anyway and only the next result waits.
// Reset (rst, synchronous) empties the set and the output register; the
// RAM is not cleared, only entries below the count are ever read.
`default_nettype none
module sample_set_statistics (
  input wire logic   clk,
  input wire logic   rst,
  sss_in_if.sink     samples,
  sss_out_if.source  results
);
  localparam int AW = sss_pkg::ADDR_W;
  localparam int CW = sss_pkg::COUNT_W;
  localparam int DW = sss_pkg::DIV_W;

  sss_pkg::state_t state, state_next;

  // set accumulators
  logic        [CW-1:0] count;
  logic signed [42:0]   sum;
  logic signed [31:0]   rmax, rmin;
  logic signed [43:0]   rsum;
  logic                 dropped;

  // final pass
  logic signed [31:0]   mean;
  logic        [AW-1:0] idx;
  logic signed [31:0]   cur_x;
  logic        [63:0]   prod;
  logic        [63:0]   acc;
  logic signed [31:0]   harm;
  logic                 harm_bad;
  logic        [48:0]   var_q;

  // shared restoring divider, one quotient bit per cycle
  logic [DW-1:0] div_q, div_rem, div_den;
  logic [6:0]    div_cnt;
  logic          div_busy;
  logic          div_start;
  logic [DW-1:0] div_num, div_dvs;
  logic [DW-1:0] trial;
  logic          trial_ge;

  logic        accept, nonzero, room;
  logic [31:0] ram_rdata;
  logic [42:0] sum_mag;
  logic [31:0] x_mag;
  logic [43:0] rsum_mag;
  logic signed [33:0] diff;
  logic [31:0] diff_mag;
  logic signed [33:0] recip;
  logic [CW-1:0] idx_inc;

  assign accept   = samples.valid && samples.ready;
  assign nonzero  = samples.sample != 32'sd0;
  assign room     = count < CW'(sss_pkg::MAX_SAMPLES);
  assign samples.ready = state == sss_pkg::S_LOAD;

  assign sum_mag  = sum[42] ? 43'(-sum) : 43'(sum);
  assign x_mag    = cur_x[31] ? 32'(-cur_x) : 32'(cur_x);
  assign rsum_mag = rsum[43] ? 44'(-rsum) : 44'(rsum);
  assign diff     = 34'(cur_x) - 34'(mean);
  assign diff_mag = diff[33] ? 32'(-diff) : 32'(diff);
  // 2^32/|x| reaches 2^32 for |x| = 1, so the quotient keeps 33 bits
  assign recip    = cur_x[31] ? -$signed({1'b0, div_q[32:0]})
                              : $signed({1'b0, div_q[32:0]});
  assign idx_inc  = CW'(idx) + CW'(1);

  assign trial    = {div_rem[DW-2:0], div_q[DW-1]};
  assign trial_ge = trial >= div_den;

  sss_ram #(.WIDTH(32), .DEPTH(sss_pkg::MAX_SAMPLES)) u_store (
    .clk   (clk),
    .we    (accept && nonzero && room),
    .waddr (count[AW-1:0]),
    .wdata (samples.sample),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sss_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and divider operands
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = '0;
    div_dvs    = '0;
    unique case (state)
      sss_pkg::S_LOAD: begin
        if (accept && samples.last) begin
          if (count == '0 && !(nonzero && room)) begin
            state_next = sss_pkg::S_EMIT;
          end else begin
            state_next = sss_pkg::S_MEAN;
          end
        end
      end
      sss_pkg::S_MEAN: begin
        div_start  = 1'b1;
        div_num    = DW'(sum_mag);
        div_dvs    = DW'(count);
        state_next = sss_pkg::S_MEAN_WAIT;
      end
      sss_pkg::S_MEAN_WAIT: begin
        if (!div_busy) state_next = sss_pkg::S_RD;
      end
      sss_pkg::S_RD:      state_next = sss_pkg::S_RD_WAIT;
      sss_pkg::S_RD_WAIT: state_next = sss_pkg::S_MUL;
      sss_pkg::S_MUL: begin
        div_start  = 1'b1;
        div_num    = DW'(64'h1_0000_0000);
        div_dvs    = DW'(x_mag);
        state_next = sss_pkg::S_RECIP_WAIT;
      end
      sss_pkg::S_RECIP_WAIT: begin
        if (!div_busy) begin
          state_next = (idx_inc == count) ? sss_pkg::S_HARM : sss_pkg::S_RD;
        end
      end
      sss_pkg::S_HARM: begin
        if (rsum == '0) begin
          state_next = sss_pkg::S_VAR;
        end else begin
          div_start  = 1'b1;
          div_num    = DW'({count, 32'h0});
          div_dvs    = DW'(rsum_mag);
          state_next = sss_pkg::S_HARM_WAIT;
        end
      end
      sss_pkg::S_HARM_WAIT: begin
        if (!div_busy) state_next = sss_pkg::S_VAR;
      end
      sss_pkg::S_VAR: begin
        div_start  = 1'b1;
        div_num    = acc;
        div_dvs    = DW'(count);
        state_next = sss_pkg::S_VAR_WAIT;
      end
      sss_pkg::S_VAR_WAIT: begin
        if (!div_busy) state_next = sss_pkg::S_EMIT;
      end
      sss_pkg::S_EMIT: begin
        if (!results.valid) state_next = sss_pkg::S_LOAD;
      end
      default: state_next = sss_pkg::S_LOAD;
    endcase
  end

  // divider
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && div_cnt == 7'(DW - 1)) begin
      div_busy <= 1'b0;
    end
    if (div_start) begin
      div_q   <= div_num;
      div_rem <= '0;
      div_den <= div_dvs;
      div_cnt <= '0;
    end else if (div_busy) begin
      div_rem <= trial_ge ? trial - div_den : trial;
      div_q   <= {div_q[DW-2:0], trial_ge};
      div_cnt <= div_cnt + 7'd1;
    end
  end

  // set accumulators and result
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      sum           <= '0;
      rmax          <= '0;
      rmin          <= '0;
      rsum          <= '0;
      dropped       <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready) results.valid <= 1'b0;
      unique case (state)
        sss_pkg::S_LOAD: begin
          if (accept && nonzero) begin
            if (room) begin
              if (count == '0 || samples.sample > rmax) rmax <= samples.sample;
              if (count == '0 || samples.sample < rmin) rmin <= samples.sample;
              sum   <= sum + 43'(samples.sample);
              count <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
          end
          acc      <= '0;
          idx      <= '0;
          harm     <= '0;
          harm_bad <= 1'b0;
          mean     <= '0;
          var_q    <= '0;
        end
        sss_pkg::S_MEAN_WAIT: begin
          if (!div_busy) mean <= sum[42] ? 32'(-div_q[31:0]) : div_q[31:0];
        end
        sss_pkg::S_RD_WAIT: cur_x <= ram_rdata;
        sss_pkg::S_MUL: prod <= 64'(diff_mag) * 64'(diff_mag);
        sss_pkg::S_RECIP_WAIT: begin
          if (!div_busy) begin
            rsum <= rsum + 44'(recip);
            acc  <= acc + (prod >> 16);
            idx  <= idx + AW'(1);
          end
        end
        sss_pkg::S_HARM: begin
          if (rsum == '0) begin
            harm     <= '0;
            harm_bad <= 1'b1;
          end
        end
        sss_pkg::S_HARM_WAIT: begin
          if (!div_busy) begin
            if (!rsum[43]) begin
              if (div_q > DW'(32'h7FFF_FFFF)) begin
                harm     <= 32'sh7FFF_FFFF;
                harm_bad <= 1'b1;
              end else begin
                harm <= div_q[31:0];
              end
            end else begin
              if (div_q > DW'(33'h0_8000_0000)) begin
                harm     <= 32'sh8000_0000;
                harm_bad <= 1'b1;
              end else begin
                harm <= 32'(-div_q[31:0]);
              end
            end
          end
        end
        sss_pkg::S_VAR_WAIT: begin
          if (!div_busy) var_q <= div_q[48:0];
        end
        sss_pkg::S_EMIT: begin
          if (!results.valid) begin
            results.valid        <= 1'b1;
            results.sample_count <= count;
            results.total        <= sum[41:0];
            results.largest      <= rmax;
            results.smallest     <= rmin;
            results.arith_mean   <= mean;
            results.harm_mean    <= harm;
            results.variance     <= var_q;
            if (count == '0) begin
              results.status <= sss_pkg::ST_EMPTY;
            end else if (harm_bad) begin
              results.status <= sss_pkg::ST_HARM;
            end else if (dropped) begin
              results.status <= sss_pkg::ST_DROPPED;
            end else begin
              results.status <= sss_pkg::ST_OK;
            end
            count   <= '0;
            sum     <= '0;
            rmax    <= '0;
            rmin    <= '0;
            rsum    <= '0;
            dropped <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ src/sss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
